>>> hw/rtl/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// Holds the item and result payload structs, action codes and field widths.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pli_pkg;

    // Field widths fixed by the item format.
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 7;
    localparam int SLOT_W     = 6;

    // Divider geometry: 64-bit product over a 32-bit span, 33-bit quotient.
    localparam int DIVIDEND_W = 2 * DATA_W;
    localparam int QUOT_W     = DATA_W + 1;
    localparam int STEP_W     = 6;

    // Breakpoint count after reset.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;

    // Action codes carried by an input item.
    localparam logic ACTION_WRITE = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    // One input item.
    typedef struct packed {
        logic                     action;
        logic [SLOT_W-1:0]        point_index;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] query_x;
    } pli_item_t;

    // One result item.
    typedef struct packed {
        logic signed [DATA_W-1:0] interpolated_y;
        logic                     out_of_range;
    } pli_result_t;

endpackage

>>> hw/rtl/pli_divider.sv
// Iterative restoring divider for the interpolation step, one quotient bit per cycle.
// Divides a 64-bit unsigned product by a nonzero 32-bit span.
// Depends on pli_pkg for the operand and quotient widths.
`timescale 1ns / 1ps

module pli_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pli_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [pli_pkg::DATA_W-1:0]      divisor,
    output logic                            done,
    output logic [pli_pkg::QUOT_W-1:0]      quotient
);
    import pli_pkg::*;

    logic [STEP_W-1:0] count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [QUOT_W-1:0] work_reg, work_next;
    logic [DATA_W-1:0] divisor_reg, divisor_next;

    logic [DATA_W:0]   trial;
    logic              fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    // The caller guarantees the quotient fits in 33 bits, so the top 31 bits
    // of the dividend start out below the divisor.
    always_comb
    begin
        trial        = {rem_reg, work_reg[QUOT_W-1]};
        fits         = (trial >= {1'b0, divisor_reg});
        count_next   = count_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        work_next    = work_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            rem_next     = {1'b0, dividend[DIVIDEND_W-1:QUOT_W]};
            work_next    = dividend[QUOT_W-1:0];
            divisor_next = divisor;
            count_next   = STEP_W'(QUOT_W);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? DATA_W'(trial - {1'b0, divisor_reg}) : trial[DATA_W-1:0];
            work_next  = {work_reg[QUOT_W-2:0], fits};
            count_next = count_reg - STEP_W'(1);
            if (count_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        work_reg    <= work_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

>>> hw/rtl/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator: breakpoint memory, scan sequencer and result register.
// Depends on pli_pkg for payload types and on pli_divider for the division step.
//
// Usage:
//   The item channel (item_valid/item_ready/item_data) carries two kinds of
//   transfer. A write stores (point_x, point_y) in slot point_index and
//   produces no result. A query looks up query_x and produces
//   exactly one transfer on the result channel (result_valid/result_ready).
//   cfg_we/cfg_wdata set the breakpoint count; write it only while idle.
// Query sequence:
//   A query fetches the last breakpoint, then scans the breakpoints in use
//   from slot 0 with one memory read each (the single read port paces the
//   scan), forms the differences, runs the split multiply and the divider,
//   and loads the output register. Out-of-range queries and hits on the
//   first breakpoint go straight from the scan to the output register.
//   One item is in flight at a time.
// Reset and stall:
//   Reset clears the sequencer and the result valid flag and sets the count
//   to 2; breakpoint contents stay undefined until written. A finished result
//   waits in the output register; the block takes the next item meanwhile,
//   but a second query holds its result until the first one is taken.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  pli_pkg::pli_item_t                    item_data,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output pli_pkg::pli_result_t                  result_data,
    input  logic                                  cfg_we,
    input  logic [pli_pkg::COUNT_W-1:0]           cfg_wdata
);
    import pli_pkg::*;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CMP_W   = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam int SLOTC_W = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;
    localparam int ENTRY_W = 2 * DATA_W;
    localparam int HALF_W  = DATA_W / 2;

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAST   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DIFF   = 3'd3;
    localparam logic [2:0] S_MUL_LO = 3'd4;
    localparam logic [2:0] S_MUL_HI = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [COUNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic                       above_reg, above_next;
    logic signed [DATA_W-1:0]   query_reg, query_next;
    logic signed [DATA_W-1:0]   prev_x_reg, prev_x_next;
    logic signed [DATA_W-1:0]   prev_y_reg, prev_y_next;
    logic signed [DATA_W-1:0]   cur_x_reg, cur_x_next;
    logic signed [DATA_W-1:0]   cur_y_reg, cur_y_next;
    logic                       dy_neg_reg, dy_neg_next;
    logic [DATA_W:0]            dy_mag_reg, dy_mag_next;
    logic [DATA_W-1:0]          dt_reg, dt_next;
    logic [DATA_W-1:0]          dx_reg, dx_next;
    logic [DIVIDEND_W-1:0]      prod_reg, prod_next;
    logic signed [DATA_W-1:0]   res_y_reg, res_y_next;
    logic                       res_oor_reg, res_oor_next;
    logic                       result_valid_reg, result_valid_next;
    pli_result_t                result_data_reg, result_data_next;

    // Breakpoint memory: x in the upper half of each entry, y in the lower.
    logic [ENTRY_W-1:0]         mem [MAX_POINTS];
    logic [ENTRY_W-1:0]         rdata_reg;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;

    logic [CMP_W-1:0]           count_ext;
    logic [CMP_W-1:0]           n_eff;
    logic [CMP_W-1:0]           last_full;
    logic [IDX_W-1:0]           last_idx;
    logic signed [DATA_W-1:0]   rd_x;
    logic signed [DATA_W-1:0]   rd_y;
    logic                       item_xfer;

    logic signed [DATA_W:0]     dy_w;
    logic [DATA_W:0]            dt_w;
    logic [DATA_W:0]            dx_w;
    logic [DIVIDEND_W-1:0]      prod_hi_sum;
    logic signed [DATA_W+2:0]   q_s;
    logic signed [DATA_W+2:0]   sum_s;
    logic signed [DATA_W-1:0]   sat_y;

    logic                       div_start;
    logic                       div_done;
    logic [QUOT_W-1:0]          div_quot;

    // Effective breakpoint count: zero counts as one, large counts clamp.
    always_comb
    begin
        count_ext = CMP_W'(count_reg);
        if (count_ext == '0)
            n_eff = CMP_W'(1);
        else if (count_ext > CMP_W'(MAX_POINTS))
            n_eff = CMP_W'(MAX_POINTS);
        else
            n_eff = count_ext;
        last_full = n_eff - CMP_W'(1);
        last_idx  = last_full[IDX_W-1:0];
    end

    assign item_ready = (state_reg == S_IDLE);
    assign item_xfer  = item_valid && item_ready;

    // Write port: slots at or beyond the memory depth are dropped.
    assign wr_en   = item_xfer && (item_data.action == ACTION_WRITE)
                  && (SLOTC_W'(item_data.point_index) < SLOTC_W'(MAX_POINTS));
    assign wr_addr = IDX_W'(item_data.point_index);

    // Read address: last breakpoint first, then a streaming scan from slot 0.
    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = last_idx;
            S_LAST:  rd_addr = '0;
            S_SCAN:  rd_addr = scan_idx_reg + IDX_W'(1);
            default: rd_addr = '0;
        endcase
    end

    // Memory access with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {item_data.point_x, item_data.point_y};
        rdata_reg <= mem[rd_addr];
    end

    assign rd_x = $signed(rdata_reg[ENTRY_W-1:DATA_W]);
    assign rd_y = $signed(rdata_reg[DATA_W-1:0]);

    // Differences across the chosen segment; the scan guarantees dx >= dt > 0.
    assign dy_w = {cur_y_reg[DATA_W-1], cur_y_reg} - {prev_y_reg[DATA_W-1], prev_y_reg};
    assign dt_w = {query_reg[DATA_W-1], query_reg} - {prev_x_reg[DATA_W-1], prev_x_reg};
    assign dx_w = {cur_x_reg[DATA_W-1], cur_x_reg} - {prev_x_reg[DATA_W-1], prev_x_reg};

    // Upper partial product of |dy| * dt added onto the lower one.
    assign prod_hi_sum = prod_reg
                       + DIVIDEND_W'({DIVIDEND_W'(dy_mag_reg * dt_reg[DATA_W-1:HALF_W]),
                                      HALF_W'(0)});

    assign div_start = (state_reg == S_MUL_HI);

    // Signed quotient added to the left breakpoint's y, then saturated.
    always_comb
    begin
        q_s = $signed({2'b00, div_quot});
        if (dy_neg_reg)
            q_s = -q_s;
        sum_s = $signed({{3{prev_y_reg[DATA_W-1]}}, prev_y_reg}) + q_s;
        if ((sum_s[DATA_W+2:DATA_W-1] == '0) || (sum_s[DATA_W+2:DATA_W-1] == '1))
            sat_y = sum_s[DATA_W-1:0];
        else if (sum_s[DATA_W+2])
            sat_y = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sat_y = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // Query sequencer.
    always_comb
    begin
        state_next        = state_reg;
        scan_idx_next     = scan_idx_reg;
        above_next        = above_reg;
        query_next        = query_reg;
        prev_x_next       = prev_x_reg;
        prev_y_next       = prev_y_reg;
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        dy_neg_next       = dy_neg_reg;
        dy_mag_next       = dy_mag_reg;
        dt_next           = dt_reg;
        dx_next           = dx_reg;
        prod_next         = prod_reg;
        res_y_next        = res_y_reg;
        res_oor_next      = res_oor_reg;
        result_valid_next = result_valid_reg;
        result_data_next  = result_data_reg;

        // A waiting result leaves on its transfer.
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer && (item_data.action == ACTION_QUERY))
                begin
                    query_next = item_data.query_x;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                above_next    = (query_reg > rd_x);
                scan_idx_next = '0;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if ((scan_idx_reg == '0) && (above_reg || (query_reg < rd_x)))
                begin
                    res_y_next   = '0;
                    res_oor_next = 1'b1;
                    state_next   = S_OUT;
                end
                else if ((scan_idx_reg != last_idx) && (query_reg > rd_x))
                begin
                    prev_x_next   = rd_x;
                    prev_y_next   = rd_y;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
                else if (scan_idx_reg == '0)
                begin
                    res_y_next   = rd_y;
                    res_oor_next = 1'b0;
                    state_next   = S_OUT;
                end
                else
                begin
                    cur_x_next = rd_x;
                    cur_y_next = rd_y;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                dy_neg_next = dy_w[DATA_W];
                dy_mag_next = dy_w[DATA_W] ? $unsigned(-dy_w) : $unsigned(dy_w);
                dt_next     = dt_w[DATA_W-1:0];
                dx_next     = dx_w[DATA_W-1:0];
                state_next  = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                prod_next  = DIVIDEND_W'(dy_mag_reg * dt_reg[HALF_W-1:0]);
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_y_next   = sat_y;
                    res_oor_next = 1'b0;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next               = 1'b1;
                    result_data_next.interpolated_y = res_y_reg;
                    result_data_next.out_of_range   = res_oor_reg;
                    state_next                      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            count_reg        <= COUNT_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                count_reg <= cfg_wdata;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        scan_idx_reg    <= scan_idx_next;
        above_reg       <= above_next;
        query_reg       <= query_next;
        prev_x_reg      <= prev_x_next;
        prev_y_reg      <= prev_y_next;
        cur_x_reg       <= cur_x_next;
        cur_y_reg       <= cur_y_next;
        dy_neg_reg      <= dy_neg_next;
        dy_mag_reg      <= dy_mag_next;
        dt_reg          <= dt_next;
        dx_reg          <= dx_next;
        prod_reg        <= prod_next;
        res_y_reg       <= res_y_next;
        res_oor_reg     <= res_oor_next;
        result_data_reg <= result_data_next;
    end

    // Division of the scaled rise by the segment span.
    pli_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_hi_sum),
        .divisor  (dx_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

endmodule

>>> hw/rtl/pli_checker.sv
// Port-level checks for the piecewise linear interpolator, bound to its top level.
// Depends on pli_pkg for payload types and action codes.
`timescale 1ns / 1ps

module pli_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  logic                         item_ready,
    input  pli_pkg::pli_item_t           item_data,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  pli_pkg::pli_result_t         result_data
);
    import pli_pkg::*;

    // A stalled result holds its value until its transfer.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed or dropped while stalled");

    // An out-of-range result always carries a zero value.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.out_of_range |-> result_data.interpolated_y == '0)
        else $error("out-of-range result with nonzero value");

    // A query transfer makes the block busy on the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_data.action == ACTION_QUERY) |=> !item_ready)
        else $error("block ready right after a query transfer");

    // A new result only appears after the block was busy with a query.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
        else $error("result appeared without a query in progress");

endmodule

bind piecewise_linear_interpolator_top pli_checker u_pli_checker (.*);
